// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by qts_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent property, clocked and held off during reset
`define QTS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("qts assertion failed");

// implication form: antecedent on one edge, consequent on the same edge
`define QTS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qts assertion failed");

// implication form: consequent on the next edge
`define QTS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qts assertion failed");

`endif

// ===== hw/rtl/qts_pkg.sv =====
// types, constants and helpers of the quoted token splitter
// no dependencies
`default_nettype none

package qts_pkg;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_SKIP   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2
  } scan_mode_e;

  // one result item
  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       tend;
    logic       trunc;
  } qts_res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic     two;
    qts_res_t r0;
    qts_res_t r1;
  } qts_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qts_fifo_stat_t;

  function automatic qts_res_t mk_char(logic [7:0] ch, logic hit);
    qts_res_t r;
    r.ch    = ch;
    r.valid = 1'b1;
    r.tend  = hit;
    r.trunc = hit;
    return r;
  endfunction

  function automatic qts_res_t mk_end(logic trunc);
    qts_res_t r;
    r.ch    = CH_NUL;
    r.valid = 1'b0;
    r.tend  = 1'b1;
    r.trunc = trunc;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qts_if.sv =====
// valid/ready channel interfaces for input bytes and result items
// no dependencies
`default_nettype none

interface qts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface qts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       token_end;
  logic       truncated;
  logic       last_of_run;

  modport source (output valid, output out_char, output char_valid, output token_end,
                  output truncated, output last_of_run, input ready);
  modport sink (input valid, input out_char, input char_valid, input token_end,
                input truncated, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/quoted_token_splitter.sv =====
// top level of the quoted token splitter: length register, scanner, queue, serializer
// depends on qts_pkg, qts_if, qts_front, qts_fifo and qts_back
`default_nettype none

// Splits a byte stream into whitespace-separated or quoted tokens. One input
// byte is accepted per cycle while the four-entry bundle queue has room; its
// results are registered in the queue before the output, which carries
// one result item per cycle while the receiver is ready, so a byte yielding
// two results (a held backslash followed by a normal byte) takes two output
// items; else input runs at one byte per cycle, set by output drain and queue.
// max_token_len resets to 256. The user must write max_token_len via cfg_we_i
// and cfg_wdata_i only while the block is idle; the block does not enforce it.
module quoted_token_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  qts_in_if.sink      in_i,
  qts_out_if.source   out_o
);
  import qts_pkg::*;

  logic [15:0]    max_len_q;
  logic           push, pop;
  qts_bundle_t    wbundle, rbundle;
  qts_fifo_stat_t fifo_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  qts_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_token_len_i (max_len_q),
    .in_i            (in_i),
    .fifo_stat_i     (fifo_stat),
    .push_o          (push),
    .bundle_o        (wbundle)
  );

  qts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbundle),
    .pop_i   (pop),
    .rdata_o (rbundle),
    .stat_o  (fifo_stat)
  );

  qts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bundle_i    (rbundle),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/qts_front.sv =====
// front end: accepts bytes, runs the scanner and pushes result bundles
// depends on qts_pkg and qts_in_if
`default_nettype none

module qts_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [15:0]             max_token_len_i,
  qts_in_if.sink                  in_i,
  input  qts_pkg::qts_fifo_stat_t fifo_stat_i,
  output logic                    push_o,
  output qts_pkg::qts_bundle_t    bundle_o
);
  import qts_pkg::*;

  scan_mode_e  mode_q, mode_d;
  logic        qdbl_q, qdbl_d;
  logic        bsp_q, bsp_d;
  logic        aqs_q, aqs_d;
  logic        drop_q, drop_d;
  logic [15:0] cnt_q, cnt_d;

  logic [7:0]  c;
  logic [15:0] limit;
  logic        lim_zero, hit_first;
  logic [16:0] k1, k2;
  logic        hit1, hit2;
  logic        is_zero, is_sp, is_q, is_bs, is_open;
  logic        accept, any;
  qts_bundle_t bundle;

  assign c        = in_i.in_char;
  // a limit of zero wraps to 65535 kept characters
  assign limit    = max_token_len_i - 16'd1;
  assign lim_zero = (limit == 16'd0);
  assign hit_first = (limit == 16'd1);
  assign k1       = {1'b0, cnt_q} + 17'd1;
  assign k2       = k1 + 17'd1;
  assign hit1     = (k1 >= {1'b0, limit});
  assign hit2     = (k2 >= {1'b0, limit});
  assign is_zero  = (c == CH_NUL);
  assign is_sp    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_q     = (c == (qdbl_q ? CH_DQUOTE : CH_SQUOTE));
  assign is_bs    = (c == CH_BSLASH);
  assign is_open  = (c == CH_SQUOTE) || (c == CH_DQUOTE);

  assign in_i.ready = !fifo_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  // output decode
  always_comb begin
    any    = 1'b0;
    bundle = '0;
    if (!drop_q) begin
      unique case (mode_q)
        MODE_PLAIN: begin
          any = 1'b1;
          if (is_zero || is_sp) begin
            bundle.r0 = mk_end(1'b0);
          end else begin
            bundle.r0 = mk_char(c, hit1);
          end
        end
        MODE_QUOTED: begin
          if (bsp_q) begin
            any = 1'b1;
            if (is_q) begin
              bundle.r0 = mk_char(c, hit1);
            end else begin
              // held backslash goes out first, then this byte as usual
              bundle.r0 = mk_char(CH_BSLASH, hit1);
              if (!hit1) begin
                if (is_zero || is_q) begin
                  bundle.two = 1'b1;
                  bundle.r1  = mk_end(1'b0);
                end else if (!is_bs) begin
                  bundle.two = 1'b1;
                  bundle.r1  = mk_char(c, hit2);
                end
              end
            end
          end else if (is_zero || is_q) begin
            any       = 1'b1;
            bundle.r0 = mk_end(1'b0);
          end else if (!(is_bs && !aqs_q)) begin
            any       = 1'b1;
            bundle.r0 = mk_char(c, hit1);
          end
        end
        default: begin
          if (!is_zero && !is_sp) begin
            if (lim_zero) begin
              any       = 1'b1;
              bundle.r0 = mk_end(1'b1);
            end else if (!is_open) begin
              any       = 1'b1;
              bundle.r0 = mk_char(c, hit_first);
            end
          end
        end
      endcase
    end
  end

  assign push_o   = accept && any;
  assign bundle_o = bundle;

  // next state
  always_comb begin
    mode_d = mode_q;
    qdbl_d = qdbl_q;
    bsp_d  = bsp_q;
    aqs_d  = aqs_q;
    drop_d = drop_q;
    cnt_d  = cnt_q;
    if (drop_q) begin
      drop_d = 1'b0;
      mode_d = MODE_SKIP;
      bsp_d  = 1'b0;
      aqs_d  = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_PLAIN: begin
          if (is_zero || is_sp) begin
            mode_d = MODE_SKIP;
            bsp_d  = 1'b0;
            aqs_d  = 1'b0;
          end else begin
            cnt_d = k1[15:0];
            if (hit1) begin
              mode_d = MODE_SKIP;
              bsp_d  = 1'b0;
              aqs_d  = 1'b0;
              drop_d = 1'b1;
            end
          end
        end
        MODE_QUOTED: begin
          if (bsp_q) begin
            bsp_d = 1'b0;
            aqs_d = 1'b0;
            cnt_d = k1[15:0];
            if (hit1) begin
              // cut on the held backslash or escaped quote
              mode_d = MODE_SKIP;
              drop_d = is_q;
            end else if (!is_q) begin
              if (is_zero || is_q) begin
                mode_d = MODE_SKIP;
              end else if (is_bs) begin
                bsp_d = 1'b1;
              end else begin
                cnt_d = k2[15:0];
                if (hit2) begin
                  mode_d = MODE_SKIP;
                  drop_d = 1'b1;
                end
              end
            end
          end else if (is_zero || is_q) begin
            mode_d = MODE_SKIP;
            aqs_d  = 1'b0;
          end else if (is_bs && !aqs_q) begin
            bsp_d = 1'b1;
          end else begin
            aqs_d = 1'b0;
            cnt_d = k1[15:0];
            if (hit1) begin
              mode_d = MODE_SKIP;
              drop_d = 1'b1;
            end
          end
        end
        default: begin
          mode_d = MODE_SKIP;
          if (!is_zero && !is_sp) begin
            cnt_d = 16'd0;
            if (is_open) begin
              qdbl_d = (c == CH_DQUOTE);
              bsp_d  = 1'b0;
              if (lim_zero) begin
                aqs_d  = 1'b0;
                drop_d = 1'b1;
              end else begin
                mode_d = MODE_QUOTED;
                aqs_d  = 1'b1;
              end
            end else if (lim_zero) begin
              bsp_d = 1'b0;
              aqs_d = 1'b0;
            end else begin
              cnt_d = 16'd1;
              if (hit_first) begin
                bsp_d  = 1'b0;
                aqs_d  = 1'b0;
                drop_d = 1'b1;
              end else begin
                mode_d = MODE_PLAIN;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SKIP;
      qdbl_q <= 1'b0;
      bsp_q  <= 1'b0;
      aqs_q  <= 1'b0;
      drop_q <= 1'b0;
      cnt_q  <= 16'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      qdbl_q <= qdbl_d;
      bsp_q  <= bsp_d;
      aqs_q  <= aqs_d;
      drop_q <= drop_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qts_fifo.sv =====
// short bundle queue between the scanner and the output serializer
// depends on qts_pkg
`default_nettype none

module qts_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  qts_pkg::qts_bundle_t    wdata_i,
  input  logic                    pop_i,
  output qts_pkg::qts_bundle_t    rdata_o,
  output qts_pkg::qts_fifo_stat_t stat_o
);
  import qts_pkg::*;

  qts_bundle_t           mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qts_back.sv =====
// back end: turns each queued bundle into one or two result items
// depends on qts_pkg and qts_out_if
`default_nettype none

module qts_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qts_pkg::qts_bundle_t    bundle_i,
  input  qts_pkg::qts_fifo_stat_t fifo_stat_i,
  output logic                    pop_o,
  qts_out_if.source               out_o
);
  import qts_pkg::*;

  logic     sel_q, sel_d;
  logic     fire;
  qts_res_t cur;

  assign cur  = sel_q ? bundle_i.r1 : bundle_i.r0;
  assign fire = out_o.valid && out_o.ready;

  assign out_o.valid       = !fifo_stat_i.empty;
  assign out_o.out_char    = cur.ch;
  assign out_o.char_valid  = cur.valid;
  assign out_o.token_end   = cur.tend;
  assign out_o.truncated   = cur.trunc;
  assign out_o.last_of_run = !bundle_i.two || sel_q;

  // second record of a pair keeps the bundle at the head one more item
  always_comb begin
    sel_d = sel_q;
    pop_o = 1'b0;
    if (fire) begin
      if (bundle_i.two && !sel_q) begin
        sel_d = 1'b1;
      end else begin
        sel_d = 1'b0;
        pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/qts_checker.sv =====
// port-level checks on the result stream, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module qts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       char_valid_i,
  input logic       token_end_i,
  input logic       truncated_i,
  input logic       last_of_run_i
);

  // an item without a character is always the end of a token and carries zero
  `QTS_ASSERT_IMPL(a_nochar_is_end, clk_i, rst_ni, out_valid_i && !char_valid_i, token_end_i && (out_char_i == 8'd0))

  `QTS_ASSERT_IMPL(a_trunc_ends, clk_i, rst_ni, out_valid_i && truncated_i, token_end_i)

  // first of a pair is always a kept character that does not end the token
  `QTS_ASSERT_IMPL(a_pair_head, clk_i, rst_ni, out_valid_i && !last_of_run_i, char_valid_i && !token_end_i)

  // the second of a pair follows right away
  `QTS_ASSERT_NEXT(a_pair_tail, clk_i, rst_ni, out_valid_i && out_ready_i && !last_of_run_i, out_valid_i)

endmodule

bind quoted_token_splitter qts_checker u_qts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_char_i    (out_o.out_char),
  .char_valid_i  (out_o.char_valid),
  .token_end_i   (out_o.token_end),
  .truncated_i   (out_o.truncated),
  .last_of_run_i (out_o.last_of_run)
);

`default_nettype wire
